// File: rtl/core/backward_lzss_decoder_top_assert.svh
// Assertion macros used by the backward LZSS decoder top level.
`ifndef BACKWARD_LZSS_DECODER_TOP_ASSERT_SVH
`define BACKWARD_LZSS_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define BLZD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("backward_lzss_decoder_top: assertion failed");
`define BLZD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("backward_lzss_decoder_top: assertion failed");
`else
`define BLZD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BLZD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/blzd_pkg.sv
// Types and constants of the backward LZSS decoder.
package blzd_pkg;

    localparam int HIST_DEPTH = 8192;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int STATUS_W   = 3;
    localparam int OFF_W      = 13;
    localparam int LEN_W      = 5;

    typedef enum logic [STATUS_W-1:0] {
        ST_DATA      = 3'd0,
        ST_DONE      = 3'd1,
        ST_BAD_REF   = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_TRUNCATED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        PH_CONTROL   = 2'd0,
        PH_ITEM      = 2'd1,
        PH_TOKEN_LOW = 2'd2
    } phase_t;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_DECODE    = 7'b0000010,
        S_LIT       = 7'b0000100,
        S_ITEM_DONE = 7'b0001000,
        S_CLOSE     = 7'b0010000,
        S_COPY_RD   = 7'b0100000,
        S_COPY_WR   = 7'b1000000
    } fsm_t;

endpackage

// File: rtl/core/backward_lzss_decoder_top.sv
// Top level of the backward LZSS decoder: control sequencer, history RAM and result register.
//
//  channel   signals                                       direction
//  in        in_valid, in_stall, in_byte, in_last          coded bytes in
//  out       out_valid, out_stall, out_byte, out_position,  decoded bytes and status out
//            out_final, status
//  cfg       cfg_we, cfg_wdata                              output_length write
//
// Each coded byte is taken in S_IDLE and decoded in S_DECODE; a literal then passes S_LIT and
// S_ITEM_DONE, a token low byte the copy loop and S_ITEM_DONE, and a closing status S_CLOSE.
// Copied bytes are read in S_COPY_RD and written in S_COPY_WR, as the RAM read is registered.
// Reset clears the control state and output_length; the history RAM is not cleared.
// A stall on the output holds the sequencer at its next result; input is stalled
// while a byte is being decoded.
`include "backward_lzss_decoder_top_assert.svh"

module backward_lzss_decoder_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    in_byte,
    input  logic                          in_last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    out_byte,
    output logic [31:0]                   out_position,
    output logic                          out_final,
    output logic [blzd_pkg::STATUS_W-1:0] status,
    input  logic                          cfg_we,
    input  logic [31:0]                   cfg_wdata
);

    import blzd_pkg::*;

    fsm_t                 state_reg, state_next;
    phase_t               phase_reg, phase_next;
    status_t              st_reg, st_next;
    logic [31:0]          olen_reg, olen_next;
    logic [31:0]          wp_reg, wp_next;
    logic [HIST_AW-1:0]   widx_reg, widx_next;
    logic [7:0]           flag_shift_reg, flag_shift_next;
    logic [3:0]           flags_left_reg, flags_left_next;
    logic [7:0]           token_high_reg, token_high_next;
    logic                 finished_reg, finished_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 last_reg, last_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [OFF_W-1:0]     off_reg, off_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic [31:0]          out_pos_reg, out_pos_next;
    logic                 out_final_reg, out_final_next;
    status_t              out_status_reg, out_status_next;

    logic                 out_free;
    logic                 emit;
    logic                 rearm;
    logic [31:0]          rearm_len;
    logic [31:0]          wp_dec;
    logic [HIST_AW-1:0]   widx_dec;
    logic [HIST_AW:0]     rd_sum;
    logic [HIST_AW-1:0]   rd_idx;
    logic [32:0]          src;
    logic                 bad_ref;
    logic [LEN_W-1:0]     len_calc;
    logic [OFF_W-1:0]     off_calc;
    logic [3:0]           fl_dec;
    logic                 mem_we;
    logic                 mem_re;
    logic [7:0]           mem_wdata;
    logic [7:0]           mem_rdata;

    blzd_ram #(
        .WIDTH (8),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (mem_we),
        .waddr (widx_dec),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (rd_idx),
        .rdata (mem_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign wp_dec    = wp_reg - 32'd1;
    assign widx_dec  = (widx_reg == '0) ? HIST_AW'(HIST_DEPTH - 1) : widx_reg - 1'b1;
    assign rd_sum    = (HIST_AW + 1)'(widx_reg) + (HIST_AW + 1)'(off_reg);
    assign rd_idx    = (rd_sum >= (HIST_AW + 1)'(HIST_DEPTH))
                       ? HIST_AW'(rd_sum - (HIST_AW + 1)'(HIST_DEPTH))
                       : HIST_AW'(rd_sum);
    assign src       = {1'b0, wp_reg} + 33'(off_reg);
    assign bad_ref   = (src >= {1'b0, olen_reg});
    assign len_calc  = LEN_W'(token_high_reg[7:4]) + LEN_W'(3);
    assign off_calc  = {1'b0, token_high_reg[3:0], byte_reg} + OFF_W'(2);
    assign fl_dec    = (flags_left_reg != 4'd0) ? flags_left_reg - 4'd1 : 4'd0;
    assign rearm_len = cfg_we ? cfg_wdata : olen_reg;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        st_next         = st_reg;
        olen_next       = olen_reg;
        wp_next         = wp_reg;
        widx_next       = widx_reg;
        flag_shift_next = flag_shift_reg;
        flags_left_next = flags_left_reg;
        token_high_next = token_high_reg;
        finished_next   = finished_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        len_next        = len_reg;
        off_next        = off_reg;
        out_byte_next   = out_byte_reg;
        out_pos_next    = out_pos_reg;
        out_final_next  = out_final_reg;
        out_status_next = out_status_reg;
        emit            = 1'b0;
        rearm           = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_wdata       = byte_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next  = in_byte;
                    last_next  = in_last;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                if (finished_reg)
                begin
                    rearm = last_reg;
                end
                else
                begin
                    case (phase_reg)
                        PH_TOKEN_LOW:
                        begin
                            len_next = len_calc;
                            off_next = off_calc;
                            if (wp_reg < 32'(len_calc))
                            begin
                                st_next    = ST_UNDERFLOW;
                                state_next = S_CLOSE;
                            end
                            else
                            begin
                                state_next = S_COPY_RD;
                            end
                        end
                        PH_ITEM:
                        begin
                            if (flag_shift_reg[7])
                            begin
                                token_high_next = byte_reg;
                                if (last_reg)
                                begin
                                    st_next    = ST_TRUNCATED;
                                    state_next = S_CLOSE;
                                end
                                else
                                begin
                                    phase_next = PH_TOKEN_LOW;
                                end
                            end
                            else
                            begin
                                state_next = S_LIT;
                            end
                        end
                        default:
                        begin
                            if (wp_reg == 32'd0 || last_reg)
                            begin
                                st_next    = ST_DONE;
                                state_next = S_CLOSE;
                            end
                            else
                            begin
                                flag_shift_next = byte_reg;
                                flags_left_next = 4'd8;
                                phase_next      = PH_ITEM;
                            end
                        end
                    endcase
                end
            end
            S_LIT:
            begin
                if (out_free)
                begin
                    mem_we          = 1'b1;
                    mem_wdata       = byte_reg;
                    wp_next         = wp_dec;
                    widx_next       = widx_dec;
                    emit            = 1'b1;
                    out_byte_next   = byte_reg;
                    out_pos_next    = wp_dec;
                    out_final_next  = 1'b0;
                    out_status_next = ST_DATA;
                    state_next      = S_ITEM_DONE;
                end
            end
            S_ITEM_DONE:
            begin
                flag_shift_next = {flag_shift_reg[6:0], 1'b0};
                flags_left_next = fl_dec;
                phase_next      = PH_ITEM;
                state_next      = S_IDLE;
                if (wp_reg == 32'd0 || last_reg)
                begin
                    st_next    = ST_DONE;
                    state_next = S_CLOSE;
                end
                else if (fl_dec == 4'd0)
                begin
                    phase_next = PH_CONTROL;
                end
            end
            S_CLOSE:
            begin
                if (out_free)
                begin
                    emit            = 1'b1;
                    out_byte_next   = 8'd0;
                    out_pos_next    = wp_reg;
                    out_final_next  = 1'b1;
                    out_status_next = st_reg;
                    state_next      = S_IDLE;
                    if (last_reg)
                    begin
                        rearm = 1'b1;
                    end
                    else
                    begin
                        finished_next = 1'b1;
                    end
                end
            end
            S_COPY_RD:
            begin
                if (bad_ref)
                begin
                    st_next    = ST_BAD_REF;
                    state_next = S_CLOSE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_COPY_WR;
                end
            end
            S_COPY_WR:
            begin
                if (out_free)
                begin
                    mem_we          = 1'b1;
                    mem_wdata       = mem_rdata;
                    wp_next         = wp_dec;
                    widx_next       = widx_dec;
                    emit            = 1'b1;
                    out_byte_next   = mem_rdata;
                    out_pos_next    = wp_dec;
                    out_final_next  = 1'b0;
                    out_status_next = ST_DATA;
                    len_next        = len_reg - LEN_W'(1);
                    state_next      = (len_reg == LEN_W'(1)) ? S_ITEM_DONE : S_COPY_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            olen_next = cfg_wdata;
            rearm     = 1'b1;
        end

        if (rearm)
        begin
            wp_next         = rearm_len;
            widx_next       = '0;
            flag_shift_next = 8'd0;
            flags_left_next = 4'd0;
            token_high_next = 8'd0;
            phase_next      = PH_CONTROL;
            finished_next   = 1'b0;
        end

        out_valid_next = emit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_CONTROL;
            olen_reg       <= 32'd0;
            wp_reg         <= 32'd0;
            widx_reg       <= '0;
            flag_shift_reg <= 8'd0;
            flags_left_reg <= 4'd0;
            token_high_reg <= 8'd0;
            finished_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            olen_reg       <= olen_next;
            wp_reg         <= wp_next;
            widx_reg       <= widx_next;
            flag_shift_reg <= flag_shift_next;
            flags_left_reg <= flags_left_next;
            token_high_reg <= token_high_next;
            finished_reg   <= finished_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg         <= st_next;
        byte_reg       <= byte_next;
        last_reg       <= last_next;
        len_reg        <= len_next;
        off_reg        <= off_next;
        out_byte_reg   <= out_byte_next;
        out_pos_reg    <= out_pos_next;
        out_final_reg  <= out_final_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign out_position = out_pos_reg;
    assign out_final    = out_final_reg;
    assign status       = out_status_reg;

    // An accepted byte always blocks the input on the following cycle.
    `BLZD_ASSERT_NXT(a_accept_stalls, clk, rst_n, in_valid && !in_stall, in_stall)
    // Only closing status transactions are marked final.
    `BLZD_ASSERT_IMP(a_final_status, clk, rst_n, out_valid, out_final == (status != ST_DATA))
    // A decoded byte always lands inside the output buffer.
    `BLZD_ASSERT_IMP(a_data_in_range, clk, rst_n, out_valid && status == ST_DATA,
                     out_position < olen_reg)

endmodule

// File: rtl/core/blzd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module blzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: dv/backward_lzss_decoder_top_tb.sv
// Self-checking testbench of the backward LZSS decoder with a decoding predictor and a result checker.
module backward_lzss_decoder_top_tb;
    import blzd_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES   = 64;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 38;
    localparam int MAX_PRINTED     = 100;

    typedef enum int {
        FAULT_NONE,
        FAULT_BAD_REF,
        FAULT_UNDERFLOW,
        FAULT_TRUNCATED,
        FAULT_NOISE
    } fault_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        int         gap;
        bit         hold;
    } coded_item_t;

    typedef struct {
        logic [7:0]  data;
        logic [31:0] addr;
        logic        fin;
        status_t     st;
    } decoded_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [7:0]          in_byte = 8'h00;
    logic                in_last = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [7:0]          out_byte;
    logic [31:0]         out_position;
    logic                out_final;
    logic [STATUS_W-1:0] status;
    logic                cfg_we = 1'b0;
    logic [31:0]         cfg_wdata = 32'h0;

    coded_item_t coded_q[$];
    decoded_t    decoded_q[$];

    logic [7:0]  hist_mem [HIST_DEPTH];
    logic [31:0] run_len;
    logic [31:0] wr_addr;
    logic [7:0]  flag_bits;
    logic [3:0]  flag_count;
    logic [7:0]  tok_hi;
    phase_t      dec_phase;
    logic        swallowing;

    logic [31:0] cfg_len = 32'h0;
    logic [31:0] phase_len [NUM_PHASES];
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          idle_left = 0;
    int          stall_left = 0;
    int          cycle_count = 0;
    int          error_count = 0;

    backward_lzss_decoder_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .out_position (out_position),
        .out_final    (out_final),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
        begin
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    task automatic push_result(logic [7:0] d, logic [31:0] a, logic f, status_t s);
        decoded_t r;
        r.data = d;
        r.addr = a;
        r.fin  = f;
        r.st   = s;
        decoded_q.push_back(r);
    endtask

    task automatic restart_run();
        wr_addr    = run_len;
        flag_bits  = 8'h00;
        flag_count = 4'd0;
        tok_hi     = 8'h00;
        dec_phase  = PH_CONTROL;
        swallowing = 1'b0;
    endtask

    task automatic close_run(status_t s, logic last);
        push_result(8'h00, wr_addr, 1'b1, s);
        if (last)
        begin
            restart_run();
        end
        else
        begin
            swallowing = 1'b1;
        end
    endtask

    task automatic emit_byte(logic [7:0] v);
        wr_addr = wr_addr - 32'd1;
        hist_mem[wr_addr[HIST_AW-1:0]] = v;
        push_result(v, wr_addr, 1'b0, ST_DATA);
    endtask

    task automatic finish_item(logic last);
        flag_bits = {flag_bits[6:0], 1'b0};
        if (flag_count != 4'd0)
        begin
            flag_count = flag_count - 4'd1;
        end
        dec_phase = PH_ITEM;
        if (wr_addr == 32'd0 || last)
        begin
            close_run(ST_DONE, last);
        end
        else if (flag_count == 4'd0)
        begin
            dec_phase = PH_CONTROL;
        end
    endtask

    task automatic decode_byte(logic [7:0] b, logic last);
        logic [15:0] tok;
        logic [4:0]  len;
        logic [12:0] off;
        logic [32:0] src;
        int          copy_len;
        int          j;
        bit          aborted;
        if (swallowing)
        begin
            if (last)
            begin
                restart_run();
            end
        end
        else if (dec_phase == PH_TOKEN_LOW)
        begin
            tok      = {tok_hi, b};
            len      = {1'b0, tok[15:12]} + 5'd3;
            off      = {1'b0, tok[11:0]} + 13'd2;
            copy_len = len;
            aborted  = 1'b0;
            if (wr_addr < {27'd0, len})
            begin
                close_run(ST_UNDERFLOW, last);
            end
            else
            begin
                for (j = 0; j < copy_len && !aborted; j++)
                begin
                    src = {1'b0, wr_addr} + {20'd0, off};
                    if (src >= {1'b0, run_len})
                    begin
                        close_run(ST_BAD_REF, last);
                        aborted = 1'b1;
                    end
                    else
                    begin
                        emit_byte(hist_mem[src[HIST_AW-1:0]]);
                    end
                end
                if (!aborted)
                begin
                    finish_item(last);
                end
            end
        end
        else if (dec_phase == PH_ITEM)
        begin
            if (flag_bits[7])
            begin
                tok_hi = b;
                if (last)
                begin
                    close_run(ST_TRUNCATED, last);
                end
                else
                begin
                    dec_phase = PH_TOKEN_LOW;
                end
            end
            else
            begin
                emit_byte(b);
                finish_item(last);
            end
        end
        else
        begin
            if (wr_addr == 32'd0 || last)
            begin
                close_run(ST_DONE, last);
            end
            else
            begin
                flag_bits  = b;
                flag_count = 4'd8;
                dec_phase  = PH_ITEM;
            end
        end
    endtask

    task automatic check_result();
        decoded_t want;
        if (decoded_q.size() == 0)
        begin
            report_error($sformatf("unexpected result: byte %02h position %08h final %0b status %0d",
                                   out_byte, out_position, out_final, status));
        end
        else
        begin
            want = decoded_q.pop_front();
            if (out_byte !== want.data)
            begin
                report_error($sformatf("out_byte %02h, expected %02h (position %08h)",
                                       out_byte, want.data, want.addr));
            end
            if (out_position !== want.addr)
            begin
                report_error($sformatf("out_position %08h, expected %08h",
                                       out_position, want.addr));
            end
            if (out_final !== want.fin)
            begin
                report_error($sformatf("out_final %0b, expected %0b (position %08h)",
                                       out_final, want.fin, want.addr));
            end
            if (status !== want.st)
            begin
                report_error($sformatf("status %0d, expected %0d (position %08h)",
                                       status, want.st, want.addr));
            end
        end
    endtask

    // Present the next coded byte once the current transaction is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_byte   <= 8'h00;
            in_last   <= 1'b0;
            idle_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                decode_byte(in_byte, in_last);
            end
            if (!in_valid || !in_stall)
            begin
                if (idle_left != 0)
                begin
                    idle_left <= idle_left - 1;
                    in_valid  <= 1'b0;
                end
                else if (coded_q.size() != 0 && (!coded_q[0].hold || decoded_q.size() == 0))
                begin
                    in_valid  <= 1'b1;
                    in_byte   <= coded_q[0].data;
                    in_last   <= coded_q[0].last;
                    idle_left <= coded_q[0].gap;
                    void'(coded_q.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_result();
            end
            if (stall_left != 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 13);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send(logic [7:0] b, logic last, bit hold);
        coded_item_t it;
        it.data = b;
        it.last = last;
        it.hold = hold || (gap_pct != 0 && $urandom_range(0, 299) == 0);
        it.gap  = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 14) : 0;
        coded_q.push_back(it);
    endtask

    task automatic write_length(logic [31:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we  <= 1'b0;
        cfg_len  = v;
        run_len  = v;
        restart_run();
        @(negedge clk);
    endtask

    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end
        while (coded_q.size() != 0 || in_valid || decoded_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic fault_t pick_fault();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            return FAULT_NONE;
        end
        else if (r == 6)
        begin
            return FAULT_BAD_REF;
        end
        else if (r == 7)
        begin
            return FAULT_UNDERFLOW;
        end
        else if (r == 8)
        begin
            return FAULT_TRUNCATED;
        end
        return FAULT_NOISE;
    endfunction

    // Builds one coded region that decodes cleanly up to an optional fault, ending on in_last.
    task automatic gen_run(int groups, fault_t fault, output int used);
        coded_item_t run_q[$];
        coded_item_t it;
        logic [7:0]  body[$];
        logic [7:0]  ctrl;
        logic [15:0] tok;
        longint      produced;
        longint      remaining;
        int          len;
        int          low;
        int          nib;
        int          lo_min;
        int          g;
        int          k;
        bit          closed_last;
        bit          swallow_tail;
        produced     = 0;
        remaining    = cfg_len;
        closed_last  = 1'b0;
        swallow_tail = 1'b0;
        it.gap       = 0;
        it.hold      = 1'b0;
        it.last      = 1'b0;
        if (fault == FAULT_NOISE)
        begin
            repeat ($urandom_range(1, 24))
            begin
                it.data = rand_byte();
                run_q.push_back(it);
            end
            run_q[run_q.size() - 1].last = 1'b1;
        end
        else
        begin
            for (g = 0; g < groups && remaining != 0; g++)
            begin
                ctrl = 8'h00;
                body.delete();
                for (k = 7; k >= 0 && remaining != 0; k--)
                begin
                    if ($urandom_range(0, 1) == 1 && produced >= 3 && remaining >= 3)
                    begin
                        len = $urandom_range(3, (remaining < 18) ? remaining : 18);
                        low = $urandom_range(0, (produced - 3 < 4095) ? produced - 3 : 4095);
                        nib = len - 3;
                        tok = {nib[3:0], low[11:0]};
                        ctrl[k] = 1'b1;
                        body.push_back(tok[15:8]);
                        body.push_back(tok[7:0]);
                        produced  += len;
                        remaining -= len;
                    end
                    else
                    begin
                        body.push_back(rand_byte());
                        produced++;
                        remaining--;
                    end
                end
                it.data = ctrl;
                run_q.push_back(it);
                foreach (body[i])
                begin
                    it.data = body[i];
                    run_q.push_back(it);
                end
            end
            if (remaining == 0)
            begin
                swallow_tail = 1'b1;
            end
            else if (fault != FAULT_NONE)
            begin
                it.data = rand_byte() | 8'h80;
                run_q.push_back(it);
                if (fault == FAULT_TRUNCATED)
                begin
                    it.data = rand_byte();
                    it.last = 1'b1;
                    run_q.push_back(it);
                    closed_last = 1'b1;
                end
                else
                begin
                    if (fault == FAULT_UNDERFLOW && remaining < 18)
                    begin
                        len = $urandom_range(remaining + 1, 18);
                        low = $urandom_range(0, 4095);
                    end
                    else
                    begin
                        len    = $urandom_range(3, 18);
                        lo_min = (produced >= 2) ? produced - 2 : 0;
                        low    = (lo_min <= 4095) ? $urandom_range(lo_min, 4095)
                                                  : $urandom_range(0, 4095);
                    end
                    nib = len - 3;
                    tok = {nib[3:0], low[11:0]};
                    it.data = tok[15:8];
                    run_q.push_back(it);
                    it.data = tok[7:0];
                    it.last = ($urandom_range(0, 1) == 1);
                    closed_last  = it.last;
                    swallow_tail = !it.last;
                    run_q.push_back(it);
                end
            end
            else if (run_q.size() != 0 && $urandom_range(0, 1) == 1)
            begin
                run_q[run_q.size() - 1].last = 1'b1;
            end
            else
            begin
                it.data = rand_byte();
                it.last = 1'b1;
                run_q.push_back(it);
            end
        end
        if (swallow_tail && !closed_last)
        begin
            it.last = 1'b0;
            repeat ($urandom_range(1, 3))
            begin
                it.data = rand_byte();
                run_q.push_back(it);
            end
            run_q[run_q.size() - 1].last = 1'b1;
        end
        used = run_q.size();
        foreach (run_q[i])
        begin
            send(run_q[i].data, run_q[i].last, 1'b0);
        end
    endtask

    initial
    begin
        int  p;
        int  sent;
        int  used;
        int  max_groups;
        bit  quiet;
        run_len = 32'h0;
        restart_run();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        gap_pct   = 20;
        stall_pct = 20;

        // Zero length closes at the first control byte, then swallows up to in_last.
        write_length(32'h0);
        send(8'hFF, 1'b0, 1'b0);
        send(8'h00, 1'b1, 1'b0);
        wait_idle();

        // Literals at both extremes, a longest overlapping copy, then a far reference.
        write_length(32'd40);
        send(8'h10, 1'b0, 1'b0);
        send(8'h00, 1'b0, 1'b0);
        send(8'hFF, 1'b0, 1'b0);
        send(8'h5A, 1'b0, 1'b0);
        send(8'hF0, 1'b0, 1'b0);
        send(8'h00, 1'b0, 1'b0);
        send(8'h01, 1'b0, 1'b0);
        send(8'h80, 1'b0, 1'b0);
        send(8'h7F, 1'b0, 1'b0);
        send(8'hC3, 1'b0, 1'b0);
        send(8'h80, 1'b0, 1'b0);
        send(8'h3F, 1'b0, 1'b0);
        send(8'hFF, 1'b1, 1'b0);
        // A token cut off by the end of the region, then a control byte carrying in_last.
        send(8'h80, 1'b0, 1'b1);
        send(8'h12, 1'b1, 1'b0);
        send(8'h80, 1'b1, 1'b0);
        wait_idle();

        // Filling the output closes the run early; a long token then underflows.
        write_length(32'd4);
        send(8'h00, 1'b0, 1'b0);
        send(8'h11, 1'b0, 1'b0);
        send(8'h22, 1'b0, 1'b0);
        send(8'h33, 1'b0, 1'b0);
        send(8'h44, 1'b0, 1'b0);
        send(8'hAA, 1'b1, 1'b0);
        send(8'h80, 1'b0, 1'b0);
        send(8'hF0, 1'b0, 1'b0);
        send(8'h01, 1'b1, 1'b0);
        wait_idle();

        phase_len[0] = $urandom_range(20, 300);
        phase_len[1] = 32'hFFFF_FFFF;
        phase_len[2] = 32'd1;
        phase_len[3] = 32'd2;
        phase_len[4] = $urandom_range(4100, 9000);
        phase_len[5] = 32'h8000_0000;
        phase_len[6] = $urandom;
        phase_len[7] = 32'd12;
        phase_len[8] = 32'd9000;
        phase_len[9] = 32'd150;

        for (p = 0; p < NUM_PHASES; p++)
        begin
            quiet     = (p == 4) || (p >= NUM_PHASES - 2);
            gap_pct   = quiet ? 0 : $urandom_range(5, 40);
            stall_pct = quiet ? 0 : $urandom_range(5, 30);
            write_length(phase_len[p]);
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                max_groups = (ITEMS_PER_PHASE - sent) / 17;
                gen_run($urandom_range(0, (max_groups < 6) ? max_groups : 6), pick_fault(), used);
                sent += (used > 0) ? used : 1;
            end
            wait_idle();
        end

        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/blzd_pkg.sv
rtl/core/blzd_ram.sv
rtl/core/backward_lzss_decoder_top.sv
dv/backward_lzss_decoder_top_tb.sv
